// File: design/integer_to_ascii_formatter_core_macros.svh
// assertion shorthands shared by the formatter modules
// every use needs clk and rst in scope
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH

// same-cycle implication
`define ITA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ita_pkg.sv
`default_nettype none

package ita_pkg;

  // fixed field widths
  localparam int VALUE_W    = 64;
  localparam int WIDTH_W    = 6;
  localparam int CHAR_W     = 8;
  // digit storage sized for the widest octal text of a 64-bit value
  localparam int MAX_DIGITS = 22;
  localparam int ND_W       = 5;
  localparam int DIG_BITS   = MAX_DIGITS * 4;

  // radix codes, anything else is hex
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_TEN     = 8'd10;

  typedef logic [MAX_DIGITS-1:0][3:0] digits_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         radix;
    logic               upper_case;
    logic               negative;
    logic [WIDTH_W-1:0] width;
    logic               zero_fill;
    logic               left_justify;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } out_t;

  // converted item handed from front to back, digit 0 is least significant
  typedef struct packed {
    digits_t            digits;
    logic [ND_W-1:0]    nd;
    logic               negative;
    logic [WIDTH_W-1:0] width;
    logic               zero_fill;
    logic               left_justify;
    logic               upper_case;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_t;

  // split bcd or binary bits into per-digit nibbles
  function automatic digits_t digit_vec(input logic dec, input logic oct,
                                        input logic [DIG_BITS-1:0] bcd_pad,
                                        input logic [DIG_BITS-1:0] bin_pad);
    digits_t r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (dec) begin
        r[i] = bcd_pad[4*i +: 4];
      end else if (oct) begin
        r[i] = {1'b0, bin_pad[3*i +: 3]};
      end else begin
        r[i] = bin_pad[4*i +: 4];
      end
    end
    return r;
  endfunction

  // digit nibble to ascii
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'b0000, d};
    end else begin
      r = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'b0000, d} - CH_TEN;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/integer_to_ascii_formatter_core.sv
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// item     | push / full           | value, radix, upper_case, negative,
//          |                       | width, zero_fill, left_justify
// result   | pop / empty           | out_char, last (one transaction per char)
//
// front: per item, the accept cycle, one bit per cycle through the double-dabble
// shifter, then the job is handed to the queue, held there while the queue is full
// back: a load state takes a job from the queue, then one character per cycle while pops keep up
// sustained rate is set by the slower side; a two-entry job queue lets each side stall alone
// reset clears control state only and holds full high; nothing is kept between items
// full stays high from acceptance until the job is queued; a stalled pop backs up to it
`default_nettype none

module integer_to_ascii_formatter_core #(
  parameter int VALUE_BITS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire ita_pkg::in_t  item,
  output logic               empty,
  input  wire logic          pop,
  output ita_pkg::out_t      result
);

  localparam int JOB_W = $bits(ita_pkg::job_t);

  ita_pkg::job_t     job;
  ita_pkg::job_t     head;
  logic [JOB_W-1:0]  q_din;
  logic [JOB_W-1:0]  q_dout;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;

  assign q_din = job;
  assign head  = q_dout;

  // conversion side
  ita_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .job    (job)
  );

  // job queue between the two sides
  ita_queue #(
    .W(JOB_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // character emitter
  ita_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

`default_nettype wire

// File: design/ita_queue.sv
`default_nettype none
`include "integer_to_ascii_formatter_core_macros.svh"

module ita_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);

  logic [1:0][W-1:0] slots;
  logic              wptr;
  logic              rptr;
  logic [1:0]        cnt;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
  end

  `ITA_ASSERT_NXT(a_push_not_lost, do_push && !do_pop, !empty, "queue lost a transaction")
  `ITA_ASSERT_NXT(a_pop_frees, do_pop && !do_push, !full, "queue stayed full after pop")

endmodule

`default_nettype wire

// File: design/ita_front.sv
`default_nettype none
`include "integer_to_ascii_formatter_core_macros.svh"

module ita_front #(
  parameter int VALUE_BITS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire ita_pkg::in_t item,
  output logic              full,
  input  wire logic         q_full,
  output logic              q_push,
  output ita_pkg::job_t     job
);

  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int DIG_BITS   = ita_pkg::DIG_BITS;
  localparam int ND_W       = ita_pkg::ND_W;

  ita_pkg::front_state_t state;
  ita_pkg::front_state_t state_next;

  logic [VALUE_BITS-1:0]         val;
  logic [VALUE_BITS-1:0]         bin;
  logic [BCD_W-1:0]              bcd;
  logic [ND_W-1:0]               nd;
  logic [CNT_W-1:0]              cnt;
  logic                          dec;
  logic                          oct;
  logic                          neg;
  logic [ita_pkg::WIDTH_W-1:0]   wid;
  logic                          zpad;
  logic                          left;
  logic                          upper;

  logic                          accept;
  logic [BCD_W-1:0]              bcd_adj;
  logic [BCD_W-1:0]              bcd_step;
  logic [VALUE_BITS-1:0]         bin_step;
  ita_pkg::digits_t              digs_step;
  logic                          nd_room;
  logic [3:0]                    dsel;
  logic [ND_W-1:0]               nd_step;

  assign accept = push && !full;

  // one double-dabble step per cycle, binary copy shifted alongside
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
    bcd_step = {bcd_adj[BCD_W-2:0], val[VALUE_BITS-1]};
    bin_step = {bin[VALUE_BITS-2:0], val[VALUE_BITS-1]};
  end

  // digit count grows by at most one per shifted bit
  always_comb begin
    digs_step = ita_pkg::digit_vec(dec, oct,
                                   {{(DIG_BITS-BCD_W){1'b0}}, bcd_step},
                                   {{(DIG_BITS-VALUE_BITS){1'b0}}, bin_step});
    nd_room   = (nd < ND_W'(ita_pkg::MAX_DIGITS));
    dsel      = digs_step[nd_room ? nd : '0];
    nd_step   = nd + ND_W'(nd_room && (dsel != 4'd0));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ita_pkg::F_IDLE: begin
        if (push) begin
          state_next = ita_pkg::F_CONV;
        end
      end
      ita_pkg::F_CONV: begin
        if (cnt == '0) begin
          state_next = ita_pkg::F_PUSH;
        end
      end
      ita_pkg::F_PUSH: begin
        if (!q_full) begin
          state_next = ita_pkg::F_IDLE;
        end
      end
      default: state_next = ita_pkg::F_IDLE;
    endcase
  end

  // outputs, no transaction is taken while reset is high
  always_comb begin
    full   = 1'b1;
    q_push = 1'b0;
    case (state)
      ita_pkg::F_IDLE: full = rst;
      ita_pkg::F_PUSH: q_push = !q_full;
      default: begin
        full   = 1'b1;
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ita_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // conversion datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      val   <= item.value[VALUE_BITS-1:0];
      bin   <= '0;
      bcd   <= '0;
      nd    <= '0;
      cnt   <= CNT_W'(VALUE_BITS - 1);
      dec   <= (item.radix == ita_pkg::RADIX_DEC);
      oct   <= (item.radix == ita_pkg::RADIX_OCT);
      neg   <= item.negative;
      wid   <= item.width;
      zpad  <= item.zero_fill;
      left  <= item.left_justify;
      upper <= item.upper_case;
    end else if (state == ita_pkg::F_CONV) begin
      val <= {val[VALUE_BITS-2:0], 1'b0};
      bin <= bin_step;
      bcd <= bcd_step;
      nd  <= nd_step;
      cnt <= cnt - CNT_W'(1);
    end
  end

  // converted job, zero still prints one digit
  always_comb begin
    job.digits       = ita_pkg::digit_vec(dec, oct,
                                          {{(DIG_BITS-BCD_W){1'b0}}, bcd},
                                          {{(DIG_BITS-VALUE_BITS){1'b0}}, bin});
    job.nd           = (nd == '0) ? ND_W'(1) : nd;
    job.negative     = neg;
    job.width        = wid;
    job.zero_fill    = zpad;
    job.left_justify = left;
    job.upper_case   = upper;
  end

  `ITA_ASSERT_NXT(a_push_done, state == ita_pkg::F_PUSH && !q_full, state == ita_pkg::F_IDLE, "front held a pushed job")
  `ITA_ASSERT_IMP(a_nd_range, state == ita_pkg::F_CONV, nd <= ND_W'(ita_pkg::MAX_DIGITS), "digit count overflow")

endmodule

`default_nettype wire

// File: design/ita_back.sv
`default_nettype none
`include "integer_to_ascii_formatter_core_macros.svh"

module ita_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ita_pkg::job_t head,
  input  wire logic          q_empty,
  output logic               q_pop,
  output ita_pkg::out_t      result,
  output logic               empty,
  input  wire logic          pop
);

  localparam int WW = ita_pkg::WIDTH_W;

  ita_pkg::back_state_t state;
  ita_pkg::back_state_t state_next;

  ita_pkg::digits_t            digits;
  logic                        upper;
  logic [WW-1:0]               k;
  logic [WW-1:0]               lead_end;
  logic [WW-1:0]               sign_end;
  logic [WW-1:0]               zero_end;
  logic [WW-1:0]               dig_end;
  logic [WW-1:0]               count;
  logic                        out_valid;
  logic [ita_pkg::CHAR_W-1:0]  out_char;
  logic                        out_last;

  logic [WW-1:0]               total;
  logic [WW-1:0]               pad;
  logic [WW-1:0]               lead_new;
  logic [WW-1:0]               sign_new;
  logic [WW-1:0]               zero_new;
  logic [WW-1:0]               dig_new;
  logic [WW-1:0]               count_new;
  logic                        adv;
  logic                        last_char;
  logic [WW-1:0]               didx;
  logic [3:0]                  dsel;
  logic [ita_pkg::CHAR_W-1:0]  ch;

  // field layout of the job at the queue head
  always_comb begin
    total     = WW'(head.nd) + WW'(head.negative);
    pad       = (head.width > total) ? head.width - total : '0;
    lead_new  = (!head.left_justify && !head.zero_fill) ? pad : '0;
    sign_new  = lead_new + WW'(head.negative);
    zero_new  = sign_new + ((!head.left_justify && head.zero_fill) ? pad : '0);
    dig_new   = zero_new + WW'(head.nd);
    count_new = dig_new + (head.left_justify ? pad : '0);
  end

  // character at position k
  always_comb begin
    didx = dig_end - WW'(1) - k;
    dsel = (didx < WW'(ita_pkg::MAX_DIGITS)) ? digits[didx[ita_pkg::ND_W-1:0]] : 4'd0;
    if (k < lead_end) begin
      ch = ita_pkg::CH_SPACE;
    end else if (k < sign_end) begin
      ch = ita_pkg::CH_MINUS;
    end else if (k < zero_end) begin
      ch = ita_pkg::CH_ZERO;
    end else if (k < dig_end) begin
      ch = ita_pkg::digit_char(dsel, upper);
    end else begin
      ch = ita_pkg::CH_SPACE;
    end
    last_char = (k == count - WW'(1));
  end

  assign adv = (state == ita_pkg::B_EMIT) && (!out_valid || pop);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ita_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_next = ita_pkg::B_EMIT;
        end
      end
      ita_pkg::B_EMIT: begin
        if (adv && last_char) begin
          state_next = ita_pkg::B_IDLE;
        end
      end
      default: state_next = ita_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = 1'b0;
    case (state)
      ita_pkg::B_IDLE: q_pop = !q_empty;
      default:         q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ita_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // job registers and character counter
  always_ff @(posedge clk) begin
    if (q_pop) begin
      digits   <= head.digits;
      upper    <= head.upper_case;
      lead_end <= lead_new;
      sign_end <= sign_new;
      zero_end <= zero_new;
      dig_end  <= dig_new;
      count    <= count_new;
      k        <= '0;
    end else if (adv) begin
      k <= k + WW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_char <= ch;
      out_last <= last_char;
    end
  end

  assign empty           = !out_valid;
  assign result.out_char = out_char;
  assign result.last     = out_last;

  `ITA_ASSERT_IMP(a_k_range, state == ita_pkg::B_EMIT, k < count, "character index past field end")
  `ITA_ASSERT_NXT(a_last_idle, adv && last_char, state == ita_pkg::B_IDLE && out_last, "last character not closing the job")

endmodule

`default_nettype wire

// File: tb/sv/integer_to_ascii_formatter_core_tb.sv
`timescale 1ns / 100ps

module integer_to_ascii_formatter_core_tb;

  // radix codes not named in the package
  localparam logic [1:0] RADIX_HEX   = 2'd2;
  localparam logic [1:0] RADIX_SPARE = 2'd3;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int TAIL_CYCLES  = 200;
  localparam int MAX_PRINTS   = 40;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          push = 1'b0;
  logic          pop = 1'b0;
  logic          full;
  logic          empty;
  ita_pkg::in_t  item_in = '0;
  ita_pkg::out_t result;

  // characters still owed by the block, oldest first
  ita_pkg::out_t pending_chars[$];
  ita_pkg::out_t want_char;

  // directed stimulus table, empty text means use the formatter model
  ita_pkg::in_t dir_stim[$];
  string        dir_text[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  integer_to_ascii_formatter_core DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item_in),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("integer_to_ascii_formatter_core_tb failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("mismatch on %s at cycle %0d: got %02h want %02h",
               what, cycle_count, got, want);
    end
    mismatch_count++;
  endtask

  function automatic ita_pkg::in_t field_item(input logic [63:0] v, input logic [1:0] rdx,
                                              input logic up, input logic neg,
                                              input logic [5:0] w, input logic zf,
                                              input logic lj);
    return '{value: v, radix: rdx, upper_case: up, negative: neg, width: w,
             zero_fill: zf, left_justify: lj};
  endfunction

  // queue a literal expected text, last marker on the final character
  function automatic void expect_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back(ita_pkg::out_t'{out_char: s[i], last: (i == s.len() - 1)});
    end
  endfunction

  // printf-style formatting of one item into expected characters
  function automatic void format_field(input ita_pkg::in_t it);
    logic [63:0] rest;
    logic [63:0] base;
    logic [3:0]  d;
    logic [7:0]  digs[$];
    logic [7:0]  txt[$];
    int          pad;
    rest = it.value;
    case (it.radix)
      ita_pkg::RADIX_DEC: base = 64'd10;
      ita_pkg::RADIX_OCT: base = 64'd8;
      default:            base = 64'd16;
    endcase
    // digits, most significant first; zero still gives one digit
    do begin
      d = 4'(rest % base);
      if (d < 4'd10) begin
        digs.push_front(ita_pkg::CH_ZERO + 8'(d));
      end else begin
        digs.push_front((it.upper_case ? ita_pkg::CH_UPPER_A : ita_pkg::CH_LOWER_A)
                        + 8'(d) - 8'd10);
      end
      rest = rest / base;
    end while (rest != 0);
    pad = int'(it.width) - digs.size() - (it.negative ? 1 : 0);
    if (pad < 0) pad = 0;
    // assemble the field around sign and digits
    if (!it.left_justify && !it.zero_fill) begin
      for (int i = 0; i < pad; i++) txt.push_back(ita_pkg::CH_SPACE);
    end
    if (it.negative) txt.push_back(ita_pkg::CH_MINUS);
    if (!it.left_justify && it.zero_fill) begin
      for (int i = 0; i < pad; i++) txt.push_back(ita_pkg::CH_ZERO);
    end
    foreach (digs[i]) txt.push_back(digs[i]);
    if (it.left_justify) begin
      for (int i = 0; i < pad; i++) txt.push_back(ita_pkg::CH_SPACE);
    end
    foreach (txt[i]) begin
      pending_chars.push_back(ita_pkg::out_t'{out_char: txt[i],
                                              last: (i == txt.size() - 1)});
    end
  endfunction

  function automatic ita_pkg::in_t random_item();
    int          nb;
    logic [63:0] v;
    logic [5:0]  w;
    nb = $urandom_range(1) ? 64 : $urandom_range(63);
    v = {$urandom, $urandom};
    if (nb == 0) begin
      v = '0;
    end else begin
      v = v >> (64 - nb);
    end
    w = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(24));
    return field_item(v, 2'($urandom_range(3)), 1'($urandom), 1'($urandom), w,
                      1'($urandom), 1'($urandom));
  endfunction

  // offer one transaction until accepted, then maybe go idle
  task automatic send_item(input ita_pkg::in_t it, input string text);
    item_in <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    if (text.len() == 0) begin
      format_field(it);
    end else begin
      expect_text(text);
    end
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic drain();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
                           input bit hold);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      send_item(random_item(), "");
    end
    push <= 1'b0;
    drain();
  endtask

  // receiver: long hold-off on request, else random stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("transaction with nothing expected", result.out_char, 8'h00);
      end else begin
        want_char = pending_chars.pop_front();
        if (result.out_char !== want_char.out_char) begin
          report_mismatch("out_char", result.out_char, want_char.out_char);
        end
        if (result.last !== want_char.last) begin
          report_mismatch("last", {7'b0, result.last}, {7'b0, want_char.last});
        end
      end
    end
  end

  // directed table: extremes, every radix, sign and padding cases
  initial begin
    dir_stim.push_back(field_item(64'd0, ita_pkg::RADIX_DEC, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0));
    dir_text.push_back("0");
    dir_stim.push_back(field_item(64'd0, ita_pkg::RADIX_DEC, 1'b0, 1'b1, 6'd0, 1'b0, 1'b0));
    dir_text.push_back("-0");
    dir_stim.push_back(field_item('1, ita_pkg::RADIX_DEC, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0));
    dir_text.push_back("18446744073709551615");
    dir_stim.push_back(field_item('1, ita_pkg::RADIX_OCT, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0));
    dir_text.push_back("1777777777777777777777");
    dir_stim.push_back(field_item('1, RADIX_HEX, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0));
    dir_text.push_back("ffffffffffffffff");
    dir_stim.push_back(field_item('1, RADIX_HEX, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0));
    dir_text.push_back("FFFFFFFFFFFFFFFF");
    dir_stim.push_back(field_item(64'h8000_0000_0000_0000, ita_pkg::RADIX_OCT, 1'b0, 1'b0,
                                  6'd0, 1'b0, 1'b0));
    dir_text.push_back("1000000000000000000000");
    dir_stim.push_back(field_item(64'h8000_0000_0000_0000, RADIX_HEX, 1'b0, 1'b0,
                                  6'd0, 1'b0, 1'b0));
    dir_text.push_back("8000000000000000");
    // unused radix code decodes as hex
    dir_stim.push_back(field_item(64'hab_cdef, RADIX_SPARE, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0));
    dir_text.push_back("abcdef");
    dir_stim.push_back(field_item(64'hdead_beef, RADIX_SPARE, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0));
    dir_text.push_back("DEADBEEF");
    dir_stim.push_back(field_item(64'd8, ita_pkg::RADIX_OCT, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0));
    dir_text.push_back("10");
    dir_stim.push_back(field_item(64'd9, ita_pkg::RADIX_DEC, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0));
    dir_text.push_back("9");
    // width equal to and below the text length adds nothing
    dir_stim.push_back(field_item(64'd12345, ita_pkg::RADIX_DEC, 1'b0, 1'b0, 6'd5, 1'b1, 1'b0));
    dir_text.push_back("12345");
    dir_stim.push_back(field_item(64'd12345, ita_pkg::RADIX_DEC, 1'b0, 1'b1, 6'd3, 1'b0, 1'b1));
    dir_text.push_back("-12345");
    dir_stim.push_back(field_item(64'd42, ita_pkg::RADIX_DEC, 1'b0, 1'b1, 6'd6, 1'b1, 1'b0));
    dir_text.push_back("-00042");
    dir_stim.push_back(field_item(64'd42, ita_pkg::RADIX_DEC, 1'b0, 1'b1, 6'd6, 1'b0, 1'b0));
    dir_text.push_back("   -42");
    dir_stim.push_back(field_item(64'd42, ita_pkg::RADIX_DEC, 1'b0, 1'b1, 6'd6, 1'b0, 1'b1));
    dir_text.push_back("-42   ");
    // left justification wins over zero padding
    dir_stim.push_back(field_item(64'hf, RADIX_HEX, 1'b0, 1'b0, 6'd4, 1'b1, 1'b1));
    dir_text.push_back("f   ");
    // widest fields
    dir_stim.push_back(field_item('1, ita_pkg::RADIX_OCT, 1'b1, 1'b1, 6'd63, 1'b1, 1'b0));
    dir_text.push_back("");
    dir_stim.push_back(field_item(64'd0, ita_pkg::RADIX_DEC, 1'b0, 1'b0, 6'd63, 1'b0, 1'b0));
    dir_text.push_back("");
    dir_stim.push_back(field_item(64'd1, ita_pkg::RADIX_DEC, 1'b0, 1'b1, 6'd63, 1'b1, 1'b1));
    dir_text.push_back("");
    dir_stim.push_back(field_item(64'h0123_4567_89ab_cdef, RADIX_HEX, 1'b1, 1'b1, 6'd40,
                                  1'b1, 1'b0));
    dir_text.push_back("");
    dir_stim.push_back(field_item(64'h7fff_ffff_ffff_ffff, ita_pkg::RADIX_DEC, 1'b1, 1'b0,
                                  6'd33, 1'b0, 1'b0));
    dir_text.push_back("");
  end

  // main sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed rows, no idling
    foreach (dir_stim[i]) begin
      send_item(dir_stim[i], dir_text[i]);
    end
    push <= 1'b0;
    drain();

    // random phases, each drains before the next
    run_phase(20, 0, 0, 1'b0);
    run_phase(20, 87, 0, 1'b0);
    run_phase(20, 0, 87, 1'b0);
    run_phase(20, 21, 21, 1'b0);
    // receiver holds off while items keep coming, so full must rise
    run_phase(10, 0, 0, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("integer_to_ascii_formatter_core_tb passed");
    end else begin
      $display("integer_to_ascii_formatter_core_tb failed");
    end
    $finish;
  end

endmodule
